>>> src/mlcd_pkg.sv
package mlcd_pkg;

    localparam int LINES_DEFAULT          = 128;
    localparam int BYTES_PER_LINE_DEFAULT = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VCOM_PERIOD = '0;

    localparam logic [15:0] VCOM_PERIOD_RESET = 16'd15000;
    localparam logic [15:0] TIMER_MAX         = 16'hffff;

    localparam logic [7:0] BYTE_UPDATE    = 8'h80;
    localparam logic [7:0] BYTE_VCOM      = 8'h40;
    localparam logic [7:0] BYTE_DUMMY     = 8'hff;
    localparam logic [7:0] BYTE_CLEAR_MEM = 8'h20;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;

    typedef enum logic [2:0] {
        MODE_DRAW    = 3'd0,
        MODE_READ    = 3'd1,
        MODE_CLEAR   = 3'd2,
        MODE_UPDATE  = 3'd3,
        MODE_BYTE    = 3'd4,
        MODE_TICK    = 3'd5,
        MODE_CLR_MEM = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SECOND,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic second;
        logic clear_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic two_res;
        logic go_clear;
        logic clear_last;
    } dp_status_t;

    function automatic logic [7:0] bit_rev(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

>>> src/mlcd_ctrl.sv
module mlcd_ctrl
    import mlcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.two_res)
                begin
                    state_next = ST_SECOND;
                end
                else if (status.go_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SECOND:
            begin
                cmd.second = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/mlcd_datapath.sv
module mlcd_datapath
    import mlcd_pkg::*;
#(
    parameter int LINES          = LINES_DEFAULT,
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [2:0]  mode,
    input  logic [6:0]  x,
    input  logic [6:0]  y,
    input  logic        color,
    input  logic [15:0] vcom_period,
    output logic        done,
    output logic        byte_valid,
    output logic [7:0]  spi_byte,
    output logic        chip_select_active,
    output logic        last_of_transfer,
    output logic        pixel_value,
    output logic        accepted,
    output logic        busy_res
);

    localparam int STORE_BYTES = LINES * BYTES_PER_LINE;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LINE_W      = $clog2(LINES + 1);
    localparam int OFF_W       = $clog2(BYTES_PER_LINE + 2);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic [LINE_W-1:0] LINE_END  = LINE_W'(LINES);
    localparam logic [OFF_W-1:0]  OFF_DATA  = OFF_W'(BYTES_PER_LINE);
    localparam logic [OFF_W-1:0]  OFF_LAST  = OFF_W'(BYTES_PER_LINE + 1);

    logic [7:0] store [STORE_BYTES];

    mode_t             mode_reg;
    logic              inside_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [2:0]        bitsel_reg;
    logic              color_reg;
    logic [7:0]        rd_data_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic              busy_tx_reg, busy_tx_next;
    logic              vcom_reg, vcom_next;
    logic [15:0]       timer_reg, timer_next;
    logic              done_reg;

    logic              inside_in;
    logic [ADDR_W-1:0] idx_in;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        bit_mask;
    logic [15:0]       period_eff;
    logic [15:0]       timer_inc;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_pix;
    logic       r_acc;
    logic       two_res;

    assign inside_in = ({2'b00, x[6:3]} < 6'(BYTES_PER_LINE)) && ({1'b0, y} < 8'(LINES));
    assign idx_in    = ADDR_W'(ADDR_W'(y) * ADDR_W'(BYTES_PER_LINE)) + ADDR_W'(x[6:3]);
    assign rd_addr   = (mode_t'(mode) == MODE_BYTE) ? faddr_reg : idx_in;

    assign bit_mask   = BYTE_UPDATE >> bitsel_reg;
    assign period_eff = (vcom_period == 16'd0) ? 16'd1 : vcom_period;
    assign timer_inc  = (timer_reg != TIMER_MAX) ? timer_reg + 16'd1 : timer_reg;

    assign mem_we    = cmd.clear_step || (cmd.exec && mode_reg == MODE_DRAW && inside_reg);
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : idx_reg;
    assign mem_wdata = cmd.clear_step ? BYTE_DUMMY
                     : (color_reg ? (rd_data_reg & ~bit_mask) : (rd_data_reg | bit_mask));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= mode_t'(mode);
            inside_reg <= inside_in;
            idx_reg    <= idx_in;
            bitsel_reg <= x[2:0];
            color_reg  <= color;
        end
    end

    always_comb
    begin
        busy_tx_next = busy_tx_reg;
        vcom_next    = vcom_reg;
        timer_next   = timer_reg;
        line_next    = line_reg;
        off_next     = off_reg;
        faddr_next   = faddr_reg;
        r_valid      = 1'b0;
        r_byte       = BYTE_ZERO;
        r_last       = 1'b0;
        r_pix        = 1'b0;
        r_acc        = 1'b0;
        two_res      = 1'b0;
        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_READ:
                begin
                    r_pix = inside_reg && ((rd_data_reg & bit_mask) == BYTE_ZERO);
                end
                MODE_UPDATE:
                begin
                    if (!busy_tx_reg)
                    begin
                        r_valid      = 1'b1;
                        r_acc        = 1'b1;
                        r_byte       = BYTE_UPDATE | (vcom_reg ? BYTE_VCOM : BYTE_ZERO);
                        vcom_next    = ~vcom_reg;
                        timer_next   = 16'd0;
                        line_next    = '0;
                        off_next     = '0;
                        faddr_next   = '0;
                        busy_tx_next = 1'b1;
                    end
                end
                MODE_BYTE:
                begin
                    if (busy_tx_reg)
                    begin
                        r_valid = 1'b1;
                        if (line_reg == LINE_END)
                        begin
                            r_byte       = BYTE_DUMMY;
                            r_last       = 1'b1;
                            busy_tx_next = 1'b0;
                            line_next    = '0;
                            off_next     = '0;
                            faddr_next   = '0;
                        end
                        else
                        begin
                            if (off_reg == '0)
                            begin
                                r_byte = bit_rev(8'(line_reg) + 8'd1);
                            end
                            else if (off_reg <= OFF_DATA)
                            begin
                                r_byte     = rd_data_reg;
                                faddr_next = faddr_reg + ADDR_W'(1);
                            end
                            else
                            begin
                                r_byte = BYTE_DUMMY;
                            end
                            if (off_reg == OFF_LAST)
                            begin
                                off_next  = '0;
                                line_next = line_reg + LINE_W'(1);
                            end
                            else
                            begin
                                off_next = off_reg + OFF_W'(1);
                            end
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (timer_inc < period_eff)
                    begin
                        timer_next = timer_inc;
                    end
                    else
                    begin
                        timer_next = 16'd0;
                        if (!busy_tx_reg)
                        begin
                            r_valid   = 1'b1;
                            r_acc     = 1'b1;
                            r_byte    = vcom_reg ? BYTE_VCOM : BYTE_ZERO;
                            vcom_next = ~vcom_reg;
                            two_res   = 1'b1;
                        end
                    end
                end
                MODE_CLR_MEM:
                begin
                    if (!busy_tx_reg)
                    begin
                        r_valid = 1'b1;
                        r_acc   = 1'b1;
                        r_byte  = BYTE_CLEAR_MEM;
                        two_res = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.two_res    = two_res;
    assign status.go_clear   = (mode_reg == MODE_CLEAR);
    assign status.clear_last = (clr_addr_reg == LAST_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            line_reg     <= '0;
            off_reg      <= '0;
            faddr_reg    <= '0;
            busy_tx_reg  <= 1'b0;
            vcom_reg     <= 1'b0;
            timer_reg    <= 16'd0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + ADDR_W'(1);
            end
            line_reg    <= line_next;
            off_reg     <= off_next;
            faddr_reg   <= faddr_next;
            busy_tx_reg <= busy_tx_next;
            vcom_reg    <= vcom_next;
            timer_reg   <= timer_next;
            done_reg    <= cmd.exec || cmd.second;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            byte_valid         <= r_valid;
            spi_byte           <= r_byte;
            chip_select_active <= r_valid || busy_tx_next;
            last_of_transfer   <= r_last;
            pixel_value        <= r_pix;
            accepted           <= r_acc;
            busy_res           <= busy_tx_next;
        end
        else if (cmd.second)
        begin
            byte_valid         <= 1'b1;
            spi_byte           <= BYTE_ZERO;
            chip_select_active <= 1'b1;
            last_of_transfer   <= 1'b1;
            pixel_value        <= 1'b0;
            accepted           <= 1'b1;
            busy_res           <= busy_tx_reg;
        end
    end

    assign done = done_reg;

endmodule

>>> src/memory_lcd_frame_streamer.sv
// Memory-LCD frame streamer. Raise start with mode, x, y and color while busy is low; the
// item is taken at that edge. Each item has a store read and then an execute step;
// a vcom or clear-memory command adds a further step for its second byte, and a clear walks the
// 1-bit framebuffer one byte per cycle, all LINES*BYTES_PER_LINE bytes (2048 by default),
// with busy high throughout. The same walk runs after reset, so busy stays high after
// rst_n rises until the walk ends; configuration writes are taken at any time. Each
// result appears on the result ports for exactly one cycle with done high and cannot be
// held off, so the receiver must take it then.
module memory_lcd_frame_streamer
    import mlcd_pkg::*;
#(
    parameter int LINES          = LINES_DEFAULT,
    parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            mode,
    input  logic [6:0]            x,
    input  logic [6:0]            y,
    input  logic                  color,
    output logic                  done,
    output logic                  byte_valid,
    output logic [7:0]            spi_byte,
    output logic                  chip_select_active,
    output logic                  last_of_transfer,
    output logic                  pixel_value,
    output logic                  accepted,
    output logic                  busy_res
);

    logic [15:0] vcom_period_reg;
    logic        cfg_hit;
    ctrl_cmd_t   cmd;
    dp_status_t  status;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_VCOM_PERIOD);
    assign prdata  = cfg_hit ? {16'd0, vcom_period_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcom_period_reg <= VCOM_PERIOD_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            vcom_period_reg <= pwdata[15:0];
        end
    end

    mlcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    mlcd_datapath #(
        .LINES          (LINES),
        .BYTES_PER_LINE (BYTES_PER_LINE)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .mode               (mode),
        .x                  (x),
        .y                  (y),
        .color              (color),
        .vcom_period        (vcom_period_reg),
        .done               (done),
        .byte_valid         (byte_valid),
        .spi_byte           (spi_byte),
        .chip_select_active (chip_select_active),
        .last_of_transfer   (last_of_transfer),
        .pixel_value        (pixel_value),
        .accepted           (accepted),
        .busy_res           (busy_res)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mlcd_pkg::*;

    localparam int STORE_BYTES = LINES_DEFAULT * BYTES_PER_LINE_DEFAULT;
    localparam int LINE_SLOTS  = BYTES_PER_LINE_DEFAULT + 2;
    localparam int FRAME_END   = LINES_DEFAULT * LINE_SLOTS;
    localparam int STALL_LIMIT = 10000;
    localparam int SCRIPT_ROWS = 23;
    localparam int PRINT_CAP   = 100;

    localparam logic [2:0] MODE_UNDEF = 3'd7;
    localparam logic [7:0] WHITE_BYTE = 8'hff;
    localparam logic [CFG_ADDR_W-1:0] PERIOD_ADDR = {CFG_IDX_VCOM_PERIOD, 2'b00};

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       cs;
        logic       last;
        logic       pix;
        logic       acc;
        logic       busy;
    } lcd_out_t;

    localparam lcd_out_t OUT_QUIET   = '0;
    localparam lcd_out_t OUT_REFUSED = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam lcd_out_t OUT_UPD0    = '{1'b1, BYTE_UPDATE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam lcd_out_t OUT_CMD_CLR = '{1'b1, BYTE_CLEAR_MEM, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam lcd_out_t OUT_CMD_END = '{1'b1, BYTE_ZERO, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    typedef struct {
        logic [2:0] op;
        logic [6:0] px;
        logic [6:0] py;
        logic       pc;
        int         ntyped;
        lcd_out_t   t0;
        lcd_out_t   t1;
    } script_row_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  start   = 1'b0;
    logic                  busy;
    logic [2:0]            mode    = '0;
    logic [6:0]            x       = '0;
    logic [6:0]            y       = '0;
    logic                  color   = 1'b0;
    logic                  done;
    logic                  byte_valid;
    logic [7:0]            spi_byte;
    logic                  chip_select_active;
    logic                  last_of_transfer;
    logic                  pixel_value;
    logic                  accepted;
    logic                  busy_res;

    memory_lcd_frame_streamer dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // display model state
    bit [7:0]    fb [STORE_BYTES];
    bit          vcom_phase;
    int unsigned frame_pos;
    bit          xfer_on;
    bit [15:0]   tick_count;
    bit [15:0]   tick_period;

    lcd_out_t    lcd_out_due [$];
    lcd_out_t    step_out [$];
    int          errors;
    int          items_sent;
    int          stall_cycles;
    bit          steady_phase;
    logic [6:0]  last_px;
    logic [6:0]  last_py;

    script_row_t script [SCRIPT_ROWS] = '{
        '{MODE_READ,    7'd0,   7'd0,   1'b0, 1, OUT_QUIET,   OUT_QUIET},
        '{MODE_DRAW,    7'd0,   7'd0,   1'b1, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_READ,    7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_DRAW,    7'd127, 7'd127, 1'b1, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_READ,    7'd127, 7'd127, 1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_DRAW,    7'd127, 7'd127, 1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_READ,    7'd127, 7'd127, 1'b1, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_DRAW,    7'd127, 7'd0,   1'b1, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_BYTE,    7'd0,   7'd0,   1'b0, 1, OUT_QUIET,   OUT_QUIET},
        '{MODE_UNDEF,   7'd127, 7'd127, 1'b1, 1, OUT_QUIET,   OUT_QUIET},
        '{MODE_TICK,    7'd0,   7'd0,   1'b0, 1, OUT_QUIET,   OUT_QUIET},
        '{MODE_CLR_MEM, 7'd0,   7'd0,   1'b0, 2, OUT_CMD_CLR, OUT_CMD_END},
        '{MODE_UPDATE,  7'd0,   7'd0,   1'b0, 1, OUT_UPD0,    OUT_QUIET},
        '{MODE_UPDATE,  7'd0,   7'd0,   1'b0, 1, OUT_REFUSED, OUT_QUIET},
        '{MODE_CLR_MEM, 7'd0,   7'd0,   1'b0, 1, OUT_REFUSED, OUT_QUIET},
        '{MODE_BYTE,    7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_BYTE,    7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_DRAW,    7'd8,   7'd0,   1'b1, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_BYTE,    7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_CLEAR,   7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_BYTE,    7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET},
        '{MODE_TICK,    7'd0,   7'd0,   1'b0, 1, OUT_REFUSED, OUT_QUIET},
        '{MODE_READ,    7'd0,   7'd0,   1'b0, 0, OUT_QUIET,   OUT_QUIET}
    };

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
        begin
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        end
    endtask

    function automatic lcd_out_t pack_out(bit v, bit [7:0] d, bit l, bit p, bit a);
        return '{v, d, v | xfer_on, l, p, a, xfer_on};
    endfunction

    task automatic streamer_step(logic [2:0] op, logic [6:0] px, logic [6:0] py, logic pc);
        bit          in_range;
        int unsigned idx;
        int unsigned ln;
        int unsigned off;
        bit [7:0]    msk;
        bit [7:0]    b;
        bit [7:0]    la;
        bit [15:0]   per;
        step_out.delete();
        in_range = (px / 8 < BYTES_PER_LINE_DEFAULT) && (py < LINES_DEFAULT);
        idx = in_range ? py * BYTES_PER_LINE_DEFAULT + px / 8 : 0;
        msk = 8'h80 >> px[2:0];
        case (op)
            MODE_DRAW:
            begin
                if (in_range)
                begin
                    fb[idx] = pc ? (fb[idx] & ~msk) : (fb[idx] | msk);
                end
                step_out.push_back(pack_out(0, 0, 0, 0, 0));
            end
            MODE_READ:
            begin
                step_out.push_back(pack_out(0, 0, 0, in_range && ((fb[idx] & msk) == 0), 0));
            end
            MODE_CLEAR:
            begin
                foreach (fb[i])
                begin
                    fb[i] = WHITE_BYTE;
                end
                step_out.push_back(pack_out(0, 0, 0, 0, 0));
            end
            MODE_UPDATE:
            begin
                if (xfer_on)
                begin
                    step_out.push_back(pack_out(0, 0, 0, 0, 0));
                end
                else
                begin
                    b = BYTE_UPDATE | (vcom_phase ? BYTE_VCOM : BYTE_ZERO);
                    vcom_phase ^= 1'b1;
                    tick_count = '0;
                    frame_pos = 0;
                    xfer_on = 1'b1;
                    step_out.push_back(pack_out(1, b, 0, 0, 1));
                end
            end
            MODE_BYTE:
            begin
                if (!xfer_on)
                begin
                    step_out.push_back(pack_out(0, 0, 0, 0, 0));
                end
                else if (frame_pos >= FRAME_END)
                begin
                    xfer_on = 1'b0;
                    frame_pos = 0;
                    step_out.push_back(pack_out(1, BYTE_DUMMY, 1, 0, 0));
                end
                else
                begin
                    ln = frame_pos / LINE_SLOTS;
                    off = frame_pos % LINE_SLOTS;
                    if (off == 0)
                    begin
                        la = 8'(ln + 1);
                        b = {<<{la}};
                    end
                    else if (off <= BYTES_PER_LINE_DEFAULT)
                    begin
                        b = fb[ln * BYTES_PER_LINE_DEFAULT + off - 1];
                    end
                    else
                    begin
                        b = BYTE_DUMMY;
                    end
                    frame_pos++;
                    step_out.push_back(pack_out(1, b, 0, 0, 0));
                end
            end
            MODE_TICK:
            begin
                per = (tick_period == 0) ? 16'd1 : tick_period;
                if (tick_count != TIMER_MAX)
                begin
                    tick_count++;
                end
                if (tick_count < per)
                begin
                    step_out.push_back(pack_out(0, 0, 0, 0, 0));
                end
                else
                begin
                    tick_count = '0;
                    if (xfer_on)
                    begin
                        step_out.push_back(pack_out(0, 0, 0, 0, 0));
                    end
                    else
                    begin
                        b = vcom_phase ? BYTE_VCOM : BYTE_ZERO;
                        vcom_phase ^= 1'b1;
                        step_out.push_back(pack_out(1, b, 0, 0, 1));
                        step_out.push_back(pack_out(1, BYTE_ZERO, 1, 0, 1));
                    end
                end
            end
            MODE_CLR_MEM:
            begin
                if (xfer_on)
                begin
                    step_out.push_back(pack_out(0, 0, 0, 0, 0));
                end
                else
                begin
                    step_out.push_back(pack_out(1, BYTE_CLEAR_MEM, 0, 0, 1));
                    step_out.push_back(pack_out(1, BYTE_ZERO, 1, 0, 1));
                end
            end
            default:
            begin
                step_out.push_back(pack_out(0, 0, 0, 0, 0));
            end
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic put_item(logic [2:0] op, logic [6:0] px, logic [6:0] py, logic pc,
                            int ntyped = 0, lcd_out_t t0 = OUT_QUIET,
                            lcd_out_t t1 = OUT_QUIET);
        int n;
        start <= 1'b1;
        mode  <= op;
        x     <= px;
        y     <= py;
        color <= pc;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        streamer_step(op, px, py, pc);
        if (ntyped == 0)
        begin
            foreach (step_out[i])
            begin
                lcd_out_due.push_back(step_out[i]);
            end
        end
        else
        begin
            lcd_out_due.push_back(t0);
            if (ntyped > 1)
            begin
                lcd_out_due.push_back(t1);
            end
        end
        n = steady_phase ? 0 : gap_len();
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic pixel_op();
        logic [6:0] px;
        logic [6:0] py;
        if ($urandom_range(0, 1) == 0)
        begin
            px = 7'($urandom_range(0, 127));
            py = 7'($urandom_range(0, 127));
        end
        else
        begin
            px = last_px;
            py = last_py;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            put_item(MODE_DRAW, px, py, 1'($urandom_range(0, 1)));
            last_px = px;
            last_py = py;
        end
        else
        begin
            put_item(MODE_READ, px, py, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic noise_item(logic [2:0] op);
        put_item(op, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (lcd_out_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic period_read(logic [15:0] want);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PERIOD_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'h0, want})
        begin
            report("vcom_period readback", rd, {16'h0, want});
        end
    endtask

    task automatic period_write(logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PERIOD_ADDR;
        pwdata  <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tick_period = v;
        period_read(v);
    endtask

    task automatic random_phase(int count, logic [15:0] per);
        int target;
        int r;
        int n;
        settle();
        period_write(per);
        steady_phase = ($urandom_range(0, 3) == 0);
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                repeat ($urandom_range(1, 8)) pixel_op();
            end
            else if (r < 65)
            begin
                if (!xfer_on)
                begin
                    noise_item(MODE_UPDATE);
                end
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
                                                : $urandom_range(1, 40);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        pixel_op();
                    else
                        noise_item(MODE_BYTE);
                end
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 6)) noise_item(MODE_TICK);
            end
            else if (r < 88)
            begin
                noise_item(MODE_CLR_MEM);
            end
            else if (r < 92)
            begin
                noise_item(MODE_UPDATE);
            end
            else if (r < 95)
            begin
                noise_item(MODE_CLEAR);
            end
            else
            begin
                noise_item(($urandom_range(0, 1) == 0) ? MODE_UNDEF
                                                       : 3'($urandom_range(0, 7)));
            end
        end
    endtask

    always @(posedge clk)
    begin : check_out
        lcd_out_t got;
        lcd_out_t want;
        if (rst_n && done)
        begin
            got = '{byte_valid, spi_byte, chip_select_active, last_of_transfer,
                    pixel_value, accepted, busy_res};
            if (lcd_out_due.size() == 0)
            begin
                report("unexpected item", 32'(got), '0);
            end
            else
            begin
                want = lcd_out_due.pop_front();
                if (got.valid !== want.valid)
                    report("byte_valid", got.valid, want.valid);
                if (got.data !== want.data)
                    report("spi_byte", got.data, want.data);
                if (got.cs !== want.cs)
                    report("chip_select_active", got.cs, want.cs);
                if (got.last !== want.last)
                    report("last_of_transfer", got.last, want.last);
                if (got.pix !== want.pix)
                    report("pixel_value", got.pix, want.pix);
                if (got.acc !== want.acc)
                    report("accepted", got.acc, want.acc);
                if (got.busy !== want.busy)
                    report("busy_res", got.busy, want.busy);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        errors       = 0;
        items_sent   = 0;
        stall_cycles = 0;
        steady_phase = 1'b0;
        last_px      = '0;
        last_py      = '0;
        foreach (fb[i])
        begin
            fb[i] = WHITE_BYTE;
        end
        vcom_phase  = 1'b0;
        frame_pos   = 0;
        xfer_on     = 1'b0;
        tick_count  = '0;
        tick_period = VCOM_PERIOD_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        period_read(VCOM_PERIOD_RESET);

        foreach (script[i])
        begin
            put_item(script[i].op, script[i].px, script[i].py, script[i].pc,
                     script[i].ntyped, script[i].t0, script[i].t1);
        end

        random_phase(180, 16'd1);
        random_phase(180, 16'd0);
        random_phase(180, 16'hffff);
        random_phase(180, 16'd2);
        random_phase(190, 16'($urandom_range(3, 20)));
        random_phase(190, 16'($urandom_range(3, 40)));

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> memory_lcd_frame_streamer.f
src/mlcd_pkg.sv
src/mlcd_ctrl.sv
src/mlcd_datapath.sv
src/memory_lcd_frame_streamer.sv
verif/tb_top.sv
